@@ rtl/crlf_dot_stuff_encoder_macros.svh @@
// Assertion macros shared by the checker of the CRLF dot-stuffing encoder.
`ifndef CRLF_DOT_STUFF_ENCODER_MACROS_SVH
`define CRLF_DOT_STUFF_ENCODER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CDSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CDSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/cdse_pkg.sv @@
// Package with constants, types and sequencing functions of the CRLF dot-stuffing encoder.
`timescale 1ns / 1ps
package cdse_pkg;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_DOT = 8'h2E;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [2:0] step_t;

  typedef enum logic [1:0] {
    TK_CR,
    TK_LF,
    TK_DOT,
    TK_DATA
  } token_t;

  // Classified input byte as handed from the front end to the emitter.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_lf;
    logic       dot_dup;
    logic       final_byte;
  } cdse_desc_t;

  // Number of beats for the line part of a descriptor (before any trailer).
  function automatic step_t head_len(input cdse_desc_t d);
    return (d.is_lf || d.dot_dup) ? step_t'(2) : step_t'(1);
  endfunction

  // Index of the last beat that a descriptor produces.
  function automatic step_t last_step(input cdse_desc_t d);
    step_t tail;
    tail = d.final_byte ? (d.is_lf ? step_t'(3) : step_t'(5)) : step_t'(0);
    return head_len(d) + tail - step_t'(1);
  endfunction

  // Which byte goes out at a given beat of a descriptor's sequence.
  function automatic token_t token_at(input cdse_desc_t d, input step_t idx);
    step_t  hl;
    step_t  k;
    token_t tok;
    hl  = head_len(d);
    tok = TK_DATA;
    if (idx < hl) begin
      if (d.is_lf) begin
        tok = (idx == step_t'(0)) ? TK_CR : TK_LF;
      end else begin
        tok = (d.dot_dup && idx == step_t'(0)) ? TK_DOT : TK_DATA;
      end
    end else begin
      // The trailer is CR LF DOT CR LF; a final line feed skips its first pair.
      k = idx - hl + (d.is_lf ? step_t'(2) : step_t'(0));
      case (k)
        3'd0:    tok = TK_CR;
        3'd1:    tok = TK_LF;
        3'd2:    tok = TK_DOT;
        3'd3:    tok = TK_CR;
        default: tok = TK_LF;
      endcase
    end
    return tok;
  endfunction

  // Push side of the queue between classifier and emitter.
  typedef struct packed {
    logic       valid;
    cdse_desc_t desc;
  } cdse_push_t;

endpackage

@@ rtl/cdse_if.sv @@
// Valid/ready channel interfaces for the input bytes and the encoded bytes.
`timescale 1ns / 1ps
interface cdse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface cdse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       message_end;

  modport source (output valid, output out_byte, output run_last, output message_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_last, input message_end,
                  output ready);
endinterface

@@ rtl/crlf_dot_stuff_encoder.sv @@
// Top level of the CRLF conversion and dot-stuffing encoder.
//
//   Channel  Direction  Beat contents
//   in_ch    sink       data_byte[7:0], final_byte
//   out_ch   source     out_byte[7:0], run_last, message_end
//
// One output byte per cycle while the sink is ready; an input byte gives one to seven beats.
// The emitter's step counter sets the rate: one beat of the current byte per unstalled cycle.
// An input beat is taken every cycle while the two-entry descriptor queue has room.
// An input beat is queued first; its first output beat then loads into the output register.
// Synchronous reset empties the queue and the output register and marks start of line.
// Each side stalls on its own; a full queue holds off the input, a stalled output holds the queue.
`timescale 1ns / 1ps
module crlf_dot_stuff_encoder
  import cdse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cdse_in_if.sink     in_ch,
  cdse_out_if.source  out_ch
);

  cdse_push_t push;
  logic       push_ready;
  logic       head_valid;
  cdse_desc_t head_desc;
  logic       pop;

  cdse_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  cdse_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop)
  );

  cdse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_desc  (head_desc),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule

@@ rtl/cdse_front.sv @@
// Front end: accepts input beats, tracks line start and classifies each byte.
`timescale 1ns / 1ps
module cdse_front
  import cdse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cdse_in_if.sink     in_ch,
  output cdse_push_t  push,
  input  logic        push_ready
);

  logic at_line_start_r;
  logic at_line_start_nxt;
  logic is_lf;
  logic accept;

  assign is_lf  = (in_ch.data_byte == CH_LF);
  assign accept = in_ch.valid && push_ready;

  assign in_ch.ready = push_ready;

  always_comb begin
    push.valid           = in_ch.valid;
    push.desc.data_byte  = in_ch.data_byte;
    push.desc.is_lf      = is_lf;
    push.desc.dot_dup    = at_line_start_r && (in_ch.data_byte == CH_DOT);
    push.desc.final_byte = in_ch.final_byte;
  end

  // A new line begins after every line feed and after every message.
  always_comb begin
    at_line_start_nxt = at_line_start_r;
    if (accept) begin
      at_line_start_nxt = is_lf || in_ch.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      at_line_start_r <= 1'b1;
    end else begin
      at_line_start_r <= at_line_start_nxt;
    end
  end

endmodule

@@ rtl/cdse_queue.sv @@
// Short descriptor queue between the front end and the emitter.
`timescale 1ns / 1ps
module cdse_queue
  import cdse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cdse_push_t  push,
  output logic        push_ready,
  output logic        head_valid,
  output cdse_desc_t  head_desc,
  input  logic        pop
);

  cdse_desc_t          entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;
  logic [QPTR_W-1:0]   wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_nxt;
  logic                do_push;
  logic                do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_desc  = entry_r[rd_ptr_r];

  assign do_push = push.valid && push_ready;
  assign do_pop  = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.desc;
    end
  end

endmodule

@@ rtl/cdse_back.sv @@
// Emitter: steps through each descriptor's byte sequence into an output register.
`timescale 1ns / 1ps
module cdse_back
  import cdse_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        head_valid,
  input  cdse_desc_t  head_desc,
  output logic        pop,
  cdse_out_if.source  out_ch
);

  step_t      idx_r;
  step_t      idx_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [7:0] out_byte_r;
  logic [7:0] out_byte_nxt;
  logic       run_last_r;
  logic       run_last_nxt;
  logic       msg_end_r;
  logic       msg_end_nxt;
  logic       advance;
  logic       at_last;
  token_t     tok;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.run_last    = run_last_r;
  assign out_ch.message_end = msg_end_r;

  // The output register is refilled when a descriptor waits and it is empty or being drained.
  assign advance = head_valid && (!out_valid_r || out_ch.ready);
  assign at_last = (idx_r == last_step(head_desc));
  assign tok     = token_at(head_desc, idx_r);
  assign pop     = advance && at_last;

  always_comb begin
    unique case (tok)
      TK_CR:   out_byte_nxt = CH_CR;
      TK_LF:   out_byte_nxt = CH_LF;
      TK_DOT:  out_byte_nxt = CH_DOT;
      TK_DATA: out_byte_nxt = head_desc.data_byte;
      default: out_byte_nxt = head_desc.data_byte;
    endcase
    run_last_nxt  = at_last;
    msg_end_nxt   = at_last && head_desc.final_byte;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (advance) begin
      out_valid_nxt = 1'b1;
      idx_nxt       = at_last ? step_t'(0) : idx_r + step_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= out_byte_nxt;
      run_last_r <= run_last_nxt;
      msg_end_r  <= msg_end_nxt;
    end
  end

endmodule

@@ rtl/cdse_checker.sv @@
// Port-level checker for the encoder, bound to the top level.
`timescale 1ns / 1ps
`include "crlf_dot_stuff_encoder_macros.svh"
module cdse_checker
  import cdse_pkg::*;
(
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       message_end
);

  `CDSE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(run_last) && $stable(message_end), "stalled output beat changed")
  `CDSE_ASSERT_SAME(a_end_is_lf, out_valid && message_end, run_last && (out_byte == CH_LF), "message end not on a closing line feed")
  `CDSE_ASSERT_SAME(a_idle_after_reset, $rose(rst_n), !out_valid, "output valid right after reset")

endmodule

bind crlf_dot_stuff_encoder cdse_checker u_cdse_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_byte    (out_ch.out_byte),
  .run_last    (out_ch.run_last),
  .message_end (out_ch.message_end)
);

@@ sim/crlf_dot_stuff_encoder_tb.sv @@
// Self-checking testbench for the CRLF conversion and dot-stuffing encoder.
`timescale 1ns / 1ps
module crlf_dot_stuff_encoder_tb;
  import cdse_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 235;
  localparam int HOLD_CYCLES  = 100;
  localparam int HOLD_AFTER   = 40;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic [7:0] value;
    logic       run_last;
    logic       message_end;
  } enc_beat_t;

  typedef struct {
    logic [7:0]  data;
    logic        fin;
    int          n_typed;
    logic [55:0] typed_seq;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  cdse_in_if  in_ch ();
  cdse_out_if out_ch ();

  crlf_dot_stuff_encoder u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  enc_beat_t expected_beats[$];
  stim_row_t stim_table[$];
  logic      line_start = 1'b1;
  int        mismatch_count = 0;
  int        inputs_taken = 0;
  int        cycle_count = 0;
  int        src_idle_pct = 31;
  int        sink_idle_pct = 79;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expands one input byte into the encoded beats it causes and advances the line state.
  function automatic int encode_input(input logic [7:0] d, input logic fin,
                                      output enc_beat_t seq [7]);
    int n;
    n = 0;
    if (d == CH_LF) begin
      seq[n] = {CH_CR, 2'b00};
      seq[n + 1] = {CH_LF, 2'b00};
      n = n + 2;
      line_start = 1'b1;
    end else begin
      if (line_start && d == CH_DOT) begin
        seq[n] = {CH_DOT, 2'b00};
        n = n + 1;
      end
      seq[n] = {d, 2'b00};
      n = n + 1;
      line_start = 1'b0;
    end
    if (fin) begin
      if (d != CH_LF) begin
        seq[n] = {CH_CR, 2'b00};
        seq[n + 1] = {CH_LF, 2'b00};
        n = n + 2;
      end
      seq[n] = {CH_DOT, 2'b00};
      seq[n + 1] = {CH_CR, 2'b00};
      seq[n + 2] = {CH_LF, 2'b01};
      n = n + 3;
      line_start = 1'b1;
    end
    seq[n - 1].run_last = 1'b1;
    return n;
  endfunction

  function automatic void add_row(input logic [7:0] d, input logic fin, input int n_typed,
                                  input logic [55:0] typed_seq);
    stim_row_t row;
    row.data      = d;
    row.fin       = fin;
    row.n_typed   = n_typed;
    row.typed_seq = typed_seq;
    stim_table.push_back(row);
  endfunction

  // Message text leaning on line feeds, dots and bare carriage returns.
  function automatic logic [7:0] random_text_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 14) return CH_LF;
    if (r < 28) return CH_DOT;
    if (r < 33) return CH_CR;
    return 8'($urandom_range(0, 255));
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_beat(input logic [7:0] d, input logic fin, input int n_typed,
                           input logic [55:0] typed_seq);
    enc_beat_t seq [7];
    enc_beat_t beat;
    int        n;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= d;
    in_ch.final_byte <= fin;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    inputs_taken++;
    n = encode_input(d, fin, seq);
    if (n_typed != 0) begin
      for (int i = 0; i < n_typed; i++) begin
        beat.value       = typed_seq[8 * (n_typed - 1 - i) +: 8];
        beat.run_last    = (i == n_typed - 1);
        beat.message_end = fin && (i == n_typed - 1);
        expected_beats.push_back(beat);
      end
    end else begin
      for (int i = 0; i < n; i++) expected_beats.push_back(seq[i]);
    end
    @(negedge clk);
  endtask

  // Receiver: random stalls, plus one long hold-off so the input side backs up.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && inputs_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    enc_beat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got out_byte=%h run_last=%b end=%b",
                 $time, out_ch.out_byte, out_ch.run_last, out_ch.message_end);
        mismatch_count++;
      end else begin
        want = expected_beats.pop_front();
        if (out_ch.out_byte !== want.value) begin
          $display("%0t: out_byte expected %h, got %h", $time, want.value, out_ch.out_byte);
          mismatch_count++;
        end
        if (out_ch.run_last !== want.run_last) begin
          $display("%0t: run_last expected %b, got %b", $time, want.run_last,
                   out_ch.run_last);
          mismatch_count++;
        end
        if (out_ch.message_end !== want.message_end) begin
          $display("%0t: message_end expected %b, got %b", $time, want.message_end,
                   out_ch.message_end);
          mismatch_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int msg_len;
    int random_sent;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.data_byte  <= 8'h00;
    in_ch.final_byte <= 1'b0;

    // A dot on the very first line is doubled too.
    add_row(CH_DOT, 1'b0, 2, 56'h2E2E);
    add_row(8'h41,  1'b0, 1, 56'h41);
    add_row(CH_DOT, 1'b0, 1, 56'h2E);
    add_row(CH_LF,  1'b0, 2, 56'h0D0A);
    add_row(CH_DOT, 1'b0, 2, 56'h2E2E);
    add_row(8'h00,  1'b0, 1, 56'h00);
    add_row(8'hFF,  1'b0, 1, 56'hFF);
    // A bare CR passes through; the following LF still gets its own CR.
    add_row(CH_CR,  1'b0, 1, 56'h0D);
    add_row(CH_LF,  1'b0, 2, 56'h0D0A);
    add_row(8'h78,  1'b1, 6, 56'h78_0D0A_2E0D0A);
    add_row(CH_DOT, 1'b1, 7, 56'h2E2E_0D0A_2E0D0A);
    // A final LF already closes the line, so only the terminator follows.
    add_row(CH_LF,  1'b1, 5, 56'h0D0A_2E0D0A);
    add_row(8'h00,  1'b1, 6, 56'h00_0D0A_2E0D0A);
    add_row(8'hFF,  1'b1, 6, 56'hFF_0D0A_2E0D0A);
    add_row(CH_CR,  1'b1, 6, 56'h0D_0D0A_2E0D0A);
    add_row(CH_CR,  1'b0, 1, 56'h0D);
    add_row(CH_LF,  1'b0, 2, 56'h0D0A);
    add_row(CH_LF,  1'b0, 2, 56'h0D0A);
    add_row(CH_DOT, 1'b0, 0, 56'h0);
    add_row(CH_LF,  1'b0, 0, 56'h0);
    add_row(8'h55,  1'b0, 0, 56'h0);
    add_row(8'hAA,  1'b0, 0, 56'h0);
    add_row(8'h2F,  1'b0, 0, 56'h0);
    add_row(CH_DOT, 1'b0, 0, 56'h0);
    add_row(8'h2D,  1'b1, 0, 56'h0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (stim_table[i])
      send_beat(stim_table[i].data, stim_table[i].fin, stim_table[i].n_typed,
                stim_table[i].typed_seq);

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent >= 2 * RANDOM_ITEMS / 3) begin
        src_idle_pct  = 0;
        sink_idle_pct = 0;
      end else if (random_sent >= RANDOM_ITEMS / 3) begin
        src_idle_pct  = 79;
        sink_idle_pct = 31;
      end
      // Mostly short messages, now and then a long one.
      msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 30) : $urandom_range(1, 10);
      for (int k = 0; k < msg_len; k++)
        send_beat(random_text_byte(), k == msg_len - 1, 0, 56'h0);
      random_sent += msg_len;
    end
    in_ch.valid <= 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

@@ crlf_dot_stuff_encoder.f @@
+incdir+rtl
rtl/cdse_pkg.sv
rtl/cdse_if.sv
rtl/cdse_front.sv
rtl/cdse_queue.sv
rtl/cdse_back.sv
rtl/crlf_dot_stuff_encoder.sv
rtl/cdse_checker.sv
sim/crlf_dot_stuff_encoder_tb.sv
